FILE: hw/rtl/dmx_universe_buffer_framer_top_defines.svh
// assertion macros for the dmx universe buffer framer
`ifndef DMX_UNIVERSE_BUFFER_FRAMER_TOP_DEFINES_SVH
`define DMX_UNIVERSE_BUFFER_FRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define DMX_UBF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMX_UBF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dmx_ubf_pkg.sv
package dmx_ubf_pkg;

  localparam int unsigned ChannelCount = 512;
  localparam int unsigned ChanNumW     = 10;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned HdrLen       = 5;

  localparam logic [ByteW-1:0] SofByte   = 8'h7E;
  localparam logic [ByteW-1:0] LabelByte = 8'h06;
  localparam logic [ByteW-1:0] StartCode = 8'h00;
  localparam logic [ByteW-1:0] EopByte   = 8'hE7;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_BLACKOUT = 2'd1,
    REQ_READ     = 2'd2,
    REQ_FRAME    = 2'd3
  } req_type_e;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_blackout;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/dmx_ubf_req_if.sv
interface dmx_ubf_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        req_type;
  logic [dmx_ubf_pkg::ChanNumW-1:0]  channel_number;
  logic [dmx_ubf_pkg::ByteW-1:0]     channel_value;

  modport source (output valid, req_type, channel_number, channel_value, input ready);
  modport sink   (input valid, req_type, channel_number, channel_value, output ready);
endinterface

FILE: hw/rtl/dmx_ubf_rsp_if.sv
interface dmx_ubf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dmx_ubf_pkg::ByteW-1:0] data_byte;
  logic                          frame_last;
  logic                          in_range;
  logic                          dirty;

  modport source (output valid, data_byte, frame_last, in_range, dirty, input ready);
  modport sink   (input valid, data_byte, frame_last, in_range, dirty, output ready);
endinterface

FILE: hw/rtl/dmx_ubf_ram.sv
module dmx_ubf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dmx_ubf_ctrl.sv
module dmx_ubf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  dmx_ubf_pkg::dp_sts_t sts_i,
  output dmx_ubf_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLANK,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   req_ready_q;
  logic   accept;

  assign accept = (state_q == ST_IDLE) && req_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = sts_i.is_blackout ? ST_BLANK : ST_RESULT;
      end
      ST_BLANK: begin
        if (sts_i.sweep_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      req_ready_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_ready_q <= (state_d == ST_IDLE);
    end
  end

  assign req_ready_o     = req_ready_q;
  assign cmd_o.accept    = accept;
  assign cmd_o.sweep     = (state_q == ST_CLEAR) || (state_q == ST_BLANK);
  assign cmd_o.load_out  = (state_q == ST_RESULT) && sts_i.out_free;

endmodule

FILE: hw/rtl/dmx_ubf_dp.sv
module dmx_ubf_dp #(
  parameter int unsigned ChannelCount = dmx_ubf_pkg::ChannelCount
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dmx_ubf_pkg::dp_cmd_t               cmd_i,
  output dmx_ubf_pkg::dp_sts_t               sts_o,
  input  logic [1:0]                         req_type_i,
  input  logic [dmx_ubf_pkg::ChanNumW-1:0]   channel_number_i,
  input  logic [dmx_ubf_pkg::ByteW-1:0]      channel_value_i,
  output logic                               rsp_valid_o,
  input  logic                               rsp_ready_i,
  output logic [dmx_ubf_pkg::ByteW-1:0]      data_byte_o,
  output logic                               frame_last_o,
  output logic                               in_range_o,
  output logic                               dirty_o
);

  localparam int unsigned AddrW    = (ChannelCount > 1) ? $clog2(ChannelCount) : 1;
  localparam int unsigned FrameLen = ChannelCount + 6;
  localparam int unsigned PosW     = $clog2(FrameLen + 1);
  localparam int unsigned ByteW    = dmx_ubf_pkg::ByteW;
  localparam int unsigned ChanNumW = dmx_ubf_pkg::ChanNumW;
  localparam logic [15:0] DataLen  = 16'(ChannelCount + 1);

  dmx_ubf_pkg::req_type_e kind;

  logic             chan_ok;
  logic [AddrW-1:0] chan_addr;
  logic [PosW-1:0]  pos_eff;
  logic [AddrW-1:0] pos_addr;
  logic             in_hdr;
  logic             in_chan;
  logic             is_last;
  logic [ByteW-1:0] hdr_byte;
  logic [ByteW-1:0] frame_const;

  logic             ram_we;
  logic             ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [ByteW-1:0] ram_wdata;
  logic [ByteW-1:0] ram_rdata;

  logic             dirty_q, dirty_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic             sweep_last;
  logic             out_valid_q, out_valid_d;

  logic             use_ram_q;
  logic [ByteW-1:0] const_q;
  logic             last_q;
  logic             ok_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_last_q;
  logic             out_ok_q;
  logic             out_dirty_q;

  assign kind      = dmx_ubf_pkg::req_type_e'(req_type_i);
  assign chan_ok   = (channel_number_i != '0) &&
                     (channel_number_i <= ChanNumW'(ChannelCount));
  assign chan_addr = AddrW'(channel_number_i - ChanNumW'(1));

  // a position past the frame cannot arise, treat it as frame start anyway
  assign pos_eff  = (pos_q >= PosW'(FrameLen)) ? '0 : pos_q;
  assign pos_addr = AddrW'(pos_eff - PosW'(dmx_ubf_pkg::HdrLen));
  assign in_hdr   = pos_eff < PosW'(dmx_ubf_pkg::HdrLen);
  assign in_chan  = !in_hdr && (pos_eff < PosW'(dmx_ubf_pkg::HdrLen + ChannelCount));
  assign is_last  = pos_eff == PosW'(FrameLen - 1);

  always_comb begin
    case (pos_eff[2:0])
      3'd0:    hdr_byte = dmx_ubf_pkg::SofByte;
      3'd1:    hdr_byte = dmx_ubf_pkg::LabelByte;
      3'd2:    hdr_byte = DataLen[7:0];
      3'd3:    hdr_byte = DataLen[15:8];
      default: hdr_byte = dmx_ubf_pkg::StartCode;
    endcase
  end

  assign frame_const = in_hdr ? hdr_byte : dmx_ubf_pkg::EopByte;

  // store port: clearing sweep owns it, otherwise the accepted item
  assign ram_we    = cmd_i.sweep ||
                     (cmd_i.accept && (kind == dmx_ubf_pkg::REQ_WRITE) && chan_ok);
  assign ram_re    = cmd_i.accept &&
                     (((kind == dmx_ubf_pkg::REQ_READ) && chan_ok) ||
                      ((kind == dmx_ubf_pkg::REQ_FRAME) && in_chan));
  assign ram_addr  = cmd_i.sweep ? sweep_cnt_q :
                     ((kind == dmx_ubf_pkg::REQ_FRAME) ? pos_addr : chan_addr);
  assign ram_wdata = cmd_i.sweep ? '0 : channel_value_i;

  dmx_ubf_ram #(
    .Width (ByteW),
    .Depth (ChannelCount)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign sweep_last  = sweep_cnt_q == AddrW'(ChannelCount - 1);
  assign sweep_cnt_d = cmd_i.sweep ? (sweep_last ? '0 : sweep_cnt_q + AddrW'(1)) : sweep_cnt_q;

  always_comb begin
    dirty_d = dirty_q;
    pos_d   = pos_q;
    if (cmd_i.accept) begin
      case (kind)
        dmx_ubf_pkg::REQ_WRITE: begin
          if (chan_ok) dirty_d = 1'b1;
        end
        dmx_ubf_pkg::REQ_BLACKOUT: begin
          dirty_d = 1'b1;
        end
        dmx_ubf_pkg::REQ_FRAME: begin
          if (pos_eff == '0) dirty_d = 1'b0;
          pos_d = is_last ? '0 : pos_eff + PosW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_d = cmd_i.load_out | (out_valid_q & ~rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q     <= 1'b0;
      pos_q       <= '0;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dirty_q     <= dirty_d;
      pos_q       <= pos_d;
      sweep_cnt_q <= sweep_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      use_ram_q <= ram_re;
      const_q   <= (kind == dmx_ubf_pkg::REQ_FRAME) ? frame_const : '0;
      last_q    <= (kind == dmx_ubf_pkg::REQ_FRAME) && is_last;
      ok_q      <= chan_ok;
    end
    if (cmd_i.load_out) begin
      out_data_q  <= use_ram_q ? ram_rdata : const_q;
      out_last_q  <= last_q;
      out_ok_q    <= ok_q;
      out_dirty_q <= dirty_q;
    end
  end

  assign sts_o.is_blackout = kind == dmx_ubf_pkg::REQ_BLACKOUT;
  assign sts_o.sweep_last  = sweep_last;
  assign sts_o.out_free    = ~out_valid_q | rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign data_byte_o  = out_data_q;
  assign frame_last_o = out_last_q;
  assign in_range_o   = out_ok_q;
  assign dirty_o      = out_dirty_q;

endmodule

FILE: hw/rtl/dmx_universe_buffer_framer_top.sv
// dmx universe buffer and frame builder
// req_i: one item per request; req_type selects write channel, blackout,
//   read channel or emit next frame byte; channel_number 1..CHANNEL_COUNT is
//   in range, other numbers leave the store alone and read back 0
// rsp_o: exactly one item per request with data_byte, frame_last, in_range
//   and dirty as they stand after the request took effect
// frame bytes come one per request: 0x7E, 0x06, length lsb, length msb,
//   start code 0x00, the channel levels, then 0xE7 with frame_last set
// order: a write, read or frame byte is registered at accept, then loaded
//   into the output register at rsp_o; a blackout sweeps the store one entry
//   per cycle over all CHANNEL_COUNT entries first; the single store port sets
//   this pace; a new request is taken only after the previous item is loaded
// reset: a sweep clears all CHANNEL_COUNT store entries and req_i.ready
//   stays low until it is done; dirty and the frame position reset to zero
// stall: the output register holds its item while rsp_o.ready is low; one
//   further item is accepted and waits until the register frees up
module dmx_universe_buffer_framer_top #(
  parameter int unsigned CHANNEL_COUNT = dmx_ubf_pkg::ChannelCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dmx_ubf_req_if.sink          req_i,
  dmx_ubf_rsp_if.source        rsp_o
);

  dmx_ubf_pkg::dp_cmd_t cmd;
  dmx_ubf_pkg::dp_sts_t sts;

  dmx_ubf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmx_ubf_dp #(
    .ChannelCount (CHANNEL_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (req_i.req_type),
    .channel_number_i (req_i.channel_number),
    .channel_value_i  (req_i.channel_value),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .data_byte_o      (rsp_o.data_byte),
    .frame_last_o     (rsp_o.frame_last),
    .in_range_o       (rsp_o.in_range),
    .dirty_o          (rsp_o.dirty)
  );

endmodule

FILE: hw/rtl/dmx_ubf_checker.sv
`include "dmx_universe_buffer_framer_top_defines.svh"

module dmx_ubf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [dmx_ubf_pkg::ByteW-1:0] data_byte_i,
  input logic                          frame_last_i,
  input logic                          in_range_i,
  input logic                          dirty_i
);

  // a stalled item holds
  `DMX_UBF_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(data_byte_i) && $stable(frame_last_i) && $stable(in_range_i) && $stable(dirty_i), "response changed while stalled")

  // the closing byte is the only one flagged
  `DMX_UBF_ASSERT_NOW(a_last_is_eop, clk_i, rst_ni, rsp_valid_i && frame_last_i, data_byte_i == dmx_ubf_pkg::EopByte, "frame_last without closing byte")

  // one item in flight at a time
  `DMX_UBF_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "ready stayed high after an accept")

endmodule

bind dmx_universe_buffer_framer_top dmx_ubf_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .data_byte_i (rsp_o.data_byte),
  .frame_last_i(rsp_o.frame_last),
  .in_range_i  (rsp_o.in_range),
  .dirty_i     (rsp_o.dirty)
);
